### sv/cosine_nearest_vector_select_macros.svh
// Assertion macros for the cosine nearest vector select block.
`ifndef COSINE_NEAREST_VECTOR_SELECT_MACROS_SVH
`define COSINE_NEAREST_VECTOR_SELECT_MACROS_SVH

`ifndef SYNTHESIS
// Property holds on every clock edge out of reset.
`define CNVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Antecedent implies consequent in the following cycle.
`define CNVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CNVS_ASSERT(lbl, prop, msg)
`define CNVS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### sv/cnvs_pkg.sv
// Types, constants and micro-op table for the cosine nearest vector select block.
package cnvs_pkg;

  localparam int CNVS_COORD_BITS = 16;
  localparam int CNVS_ID_BITS    = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int OP_W            = 4;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_Z = 2'd2;

  // Start of each micro-op group
  localparam logic [OP_W-1:0] OP_DOT  = 4'd0;
  localparam logic [OP_W-1:0] OP_NORM = 4'd3;
  localparam logic [OP_W-1:0] OP_DSQ  = 4'd6;
  localparam logic [OP_W-1:0] OP_CMP  = 4'd8;

  typedef enum logic [3:0] {
    A_QX, A_QY, A_QZ, A_EX, A_EY, A_EZ, A_DOT, A_DSQ, A_BDSQ
  } a_src_t;

  typedef enum logic [2:0] {
    B_EX, B_EY, B_EZ, B_DOT, B_BNORM, B_NORM
  } b_src_t;

  typedef enum logic [1:0] {
    G_DOT, G_NORM, G_DSQ, G_CMP
  } grp_t;

  typedef struct packed {
    a_src_t     a_src;
    b_src_t     b_src;
    logic [1:0] sh;     // limb position of the product, in coordinate widths
    logic       clr;    // start a fresh accumulation
    logic       sub;    // subtract instead of add
    logic       last;   // final op of its group
    grp_t       grp;
  } uop_t;

  function automatic uop_t uop_decode(input logic [OP_W-1:0] op);
    uop_t u;
    u = '{a_src: A_QX, b_src: B_EX, sh: 2'd0, clr: 1'b0, sub: 1'b0,
          last: 1'b0, grp: G_DOT};
    unique case (op)
      4'd0:  begin u.a_src = A_QX; u.b_src = B_EX; u.clr = 1'b1; end
      4'd1:  begin u.a_src = A_QY; u.b_src = B_EY; end
      4'd2:  begin u.a_src = A_QZ; u.b_src = B_EZ; u.last = 1'b1; end
      4'd3:  begin u.a_src = A_EX; u.b_src = B_EX; u.clr = 1'b1; u.grp = G_NORM; end
      4'd4:  begin u.a_src = A_EY; u.b_src = B_EY; u.grp = G_NORM; end
      4'd5:  begin u.a_src = A_EZ; u.b_src = B_EZ; u.last = 1'b1; u.grp = G_NORM; end
      4'd6:  begin u.a_src = A_DOT; u.b_src = B_DOT; u.clr = 1'b1; u.grp = G_DSQ; end
      4'd7:  begin
        u.a_src = A_DOT; u.b_src = B_DOT; u.sh = 2'd1; u.last = 1'b1; u.grp = G_DSQ;
      end
      4'd8:  begin u.a_src = A_DSQ; u.b_src = B_BNORM; u.clr = 1'b1; u.grp = G_CMP; end
      4'd9:  begin u.a_src = A_DSQ; u.b_src = B_BNORM; u.sh = 2'd1; u.grp = G_CMP; end
      4'd10: begin u.a_src = A_DSQ; u.b_src = B_BNORM; u.sh = 2'd2; u.grp = G_CMP; end
      4'd11: begin u.a_src = A_DSQ; u.b_src = B_BNORM; u.sh = 2'd3; u.grp = G_CMP; end
      4'd12: begin u.a_src = A_BDSQ; u.b_src = B_NORM; u.sub = 1'b1; u.grp = G_CMP; end
      4'd13: begin
        u.a_src = A_BDSQ; u.b_src = B_NORM; u.sh = 2'd1; u.sub = 1'b1; u.grp = G_CMP;
      end
      4'd14: begin
        u.a_src = A_BDSQ; u.b_src = B_NORM; u.sh = 2'd2; u.sub = 1'b1; u.grp = G_CMP;
      end
      4'd15: begin
        u.a_src = A_BDSQ; u.b_src = B_NORM; u.sh = 2'd3; u.sub = 1'b1;
        u.last = 1'b1; u.grp = G_CMP;
      end
      default: ;
    endcase
    return u;
  endfunction

endpackage

### sv/cosine_nearest_vector_select.sv
// Cosine-similarity argmax over a stream of 3-D vectors against a configured query.
// One entry is worked at a time: s_tready is high only in IDLE, so a new entry waits for
// a full compare, an early stop when the dot product is not positive, or a first hit,
// plus any result stall on the last entry. The single shared multiplier and its accumulator
// run 3 + 3 + 2 + 8 products per entry plus a settle and check per group.
// Reset (rst, synchronous): query registers cleared to 0, running best dropped, no result.
module cosine_nearest_vector_select
  import cnvs_pkg::*;
#(
  parameter int COORD_BITS = CNVS_COORD_BITS,
  parameter int ID_BITS    = CNVS_ID_BITS
) (
  input  logic                                        clk,
  input  logic                                        rst,
  // Entry stream
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  // s_tdata, low bit up: entry_id, entry_x, entry_y, entry_z, zero pad
  input  logic [((ID_BITS+3*COORD_BITS+7)/8)*8-1:0]   s_tdata,
  input  logic                                        s_tlast,   // last_entry
  // Result stream
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  // m_tdata, low bit up: best_id, zero pad
  output logic [((ID_BITS+7)/8)*8-1:0]                m_tdata,
  output logic                                        m_tuser,   // found
  // Config write channel
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]                        cfg_index,
  input  logic [COORD_BITS-1:0]                       cfg_data
);

  `include "cosine_nearest_vector_select_macros.svh"

  // Datapath widths. Dot and squared norm of an entry stay below 2^(2*COORD_BITS),
  // so squared dot is 4 limbs and the cross products are 6 limbs of COORD_BITS.
  localparam int TDW_OUT = ((ID_BITS+7)/8)*8;
  localparam int DW      = 2*COORD_BITS;
  localparam int SW      = 4*COORD_BITS;
  localparam int AW      = COORD_BITS+1;
  localparam int BW      = 2*COORD_BITS+1;
  localparam int PW      = AW+BW;
  localparam int ACW     = 6*COORD_BITS+2;

  typedef enum logic [2:0] {IDLE, ISSUE, SETTLE, CHECK, FINISH} state_t;

  state_t state;

  // Query registers
  logic signed [COORD_BITS-1:0] qx, qy, qz;

  // Entry under work
  logic [ID_BITS-1:0]           ent_id;
  logic signed [COORD_BITS-1:0] ex, ey, ez;
  logic                         ent_last;
  logic [DW-1:0]                dot_e;
  logic [DW-1:0]                norm_e;
  logic [SW-1:0]                dsq_e;

  // Running best: squared dot and squared norm kept for the cross compare
  logic                         have_best;
  logic [DW-1:0]                best_norm;
  logic [SW-1:0]                best_dsq;
  logic [ID_BITS-1:0]           best_ident;

  // Sequencer and shared multiply-accumulate
  logic [OP_W-1:0]              op;
  uop_t                         u;
  grp_t                         chk_grp;
  logic signed [AW-1:0]         a_op;
  logic signed [BW-1:0]         b_op;
  logic signed [PW-1:0]         prod_c;
  logic signed [PW-1:0]         prod;
  logic                         p_vld;
  logic [1:0]                   p_sh;
  logic                         p_clr;
  logic                         p_sub;
  logic signed [ACW-1:0]        p_ext;
  logic signed [ACW-1:0]        p_shf;
  logic signed [ACW-1:0]        acc_base;
  logic signed [ACW-1:0]        acc_next;
  logic signed [ACW-1:0]        acc;
  logic                         acc_pos;

  logic [ID_BITS-1:0]           out_id;
  logic                         out_found;

  assign s_tready  = (state == IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = TDW_OUT'(out_id);
  assign m_tuser   = out_found;

  assign u = uop_decode(op);

  // Operand select: coordinates sign-extend, limbs and norms zero-extend
  always_comb begin
    case (u.a_src)
      A_QX:    a_op = {qx[COORD_BITS-1], qx};
      A_QY:    a_op = {qy[COORD_BITS-1], qy};
      A_QZ:    a_op = {qz[COORD_BITS-1], qz};
      A_EX:    a_op = {ex[COORD_BITS-1], ex};
      A_EY:    a_op = {ey[COORD_BITS-1], ey};
      A_EZ:    a_op = {ez[COORD_BITS-1], ez};
      A_DOT:   a_op = {1'b0, dot_e[u.sh[0]*COORD_BITS +: COORD_BITS]};
      A_DSQ:   a_op = {1'b0, dsq_e[u.sh*COORD_BITS +: COORD_BITS]};
      A_BDSQ:  a_op = {1'b0, best_dsq[u.sh*COORD_BITS +: COORD_BITS]};
      default: a_op = '0;
    endcase
    case (u.b_src)
      B_EX:    b_op = {{(COORD_BITS+1){ex[COORD_BITS-1]}}, ex};
      B_EY:    b_op = {{(COORD_BITS+1){ey[COORD_BITS-1]}}, ey};
      B_EZ:    b_op = {{(COORD_BITS+1){ez[COORD_BITS-1]}}, ez};
      B_DOT:   b_op = {1'b0, dot_e};
      B_BNORM: b_op = {1'b0, best_norm};
      B_NORM:  b_op = {1'b0, norm_e};
      default: b_op = '0;
    endcase
  end

  assign prod_c = a_op * b_op;

  // Accumulate stage, fed from the registered product in the cycle after the multiplier
  always_comb begin
    p_ext    = {{(ACW-PW){prod[PW-1]}}, prod};
    p_shf    = p_ext <<< (int'(p_sh) * COORD_BITS);
    acc_base = p_clr ? '0 : acc;
    acc_next = p_sub ? (acc_base - p_shf) : (acc_base + p_shf);
  end

  assign acc_pos = !acc[ACW-1] && (acc != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      qx        <= '0;
      qy        <= '0;
      qz        <= '0;
      have_best <= 1'b0;
      p_vld     <= 1'b0;
      m_tvalid  <= 1'b0;
      op        <= OP_DOT;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_QUERY_X: qx <= cfg_data;
          REG_QUERY_Y: qy <= cfg_data;
          REG_QUERY_Z: qz <= cfg_data;
          default: ;
        endcase
      end

      // A result taken this cycle drops valid unless the next one loads right now
      if (m_tvalid && m_tready && !(state == FINISH && ent_last)) m_tvalid <= 1'b0;

      if (p_vld) acc <= acc_next;
      p_vld <= (state == ISSUE);

      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            ent_id   <= s_tdata[ID_BITS-1:0];
            ex       <= s_tdata[ID_BITS +: COORD_BITS];
            ey       <= s_tdata[ID_BITS+COORD_BITS +: COORD_BITS];
            ez       <= s_tdata[ID_BITS+2*COORD_BITS +: COORD_BITS];
            ent_last <= s_tlast;
            op       <= OP_DOT;
            state    <= ISSUE;
          end
        end
        ISSUE: begin
          prod    <= prod_c;
          p_sh    <= u.sh;
          p_clr   <= u.clr;
          p_sub   <= u.sub;
          chk_grp <= u.grp;
          op      <= op + 1'b1;
          if (u.last) state <= SETTLE;
        end
        SETTLE: state <= CHECK;
        CHECK: begin
          unique case (chk_grp)
            G_DOT: begin
              // Only a positive dot product can score above zero
              if (acc_pos) begin
                dot_e <= acc[DW-1:0];
                op    <= OP_NORM;
                state <= ISSUE;
              end else begin
                state <= FINISH;
              end
            end
            G_NORM: begin
              norm_e <= acc[DW-1:0];
              op     <= OP_DSQ;
              state  <= ISSUE;
            end
            G_DSQ: begin
              dsq_e <= acc[SW-1:0];
              if (!have_best) begin
                have_best  <= 1'b1;
                best_dsq   <= acc[SW-1:0];
                best_norm  <= norm_e;
                best_ident <= ent_id;
                state      <= FINISH;
              end else begin
                op    <= OP_CMP;
                state <= ISSUE;
              end
            end
            G_CMP: begin
              // acc = dot_e^2 * norm_b - dot_b^2 * norm_e; strict win only
              if (acc_pos) begin
                best_dsq   <= dsq_e;
                best_norm  <= norm_e;
                best_ident <= ent_id;
              end
              state <= FINISH;
            end
            default: state <= FINISH;
          endcase
        end
        FINISH: begin
          if (!ent_last) begin
            state <= IDLE;
          end else if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            out_id    <= have_best ? best_ident : '0;
            out_found <= have_best;
            have_best <= 1'b0;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // A result without a hit carries id zero
  `CNVS_ASSERT(a_nohit_id_zero, !(m_tvalid && !m_tuser) || (m_tdata == '0), "id set without hit")
  // The accumulator pipe is drained before any group result is read
  `CNVS_ASSERT(a_pipe_drained, !(state == CHECK) || !p_vld, "check with pending product")
  // A held best always has a nonzero squared norm
  `CNVS_ASSERT(a_best_norm, !have_best || (best_norm != '0), "best with zero norm")
  // An accepted entry starts the dot product group
  `CNVS_ASSERT_NEXT(a_start_dot, s_tvalid && s_tready, (state == ISSUE) && (op == OP_DOT), "bad start")

endmodule
